// File: hdl/tower_peak_slice_statistics_unit_macros.svh
// Assertion helpers for the tower statistics block.
// Both forms sample on clk; the first is held off during rst.
`ifndef TOWER_PEAK_SLICE_STATISTICS_UNIT_MACROS_SVH
`define TOWER_PEAK_SLICE_STATISTICS_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TPSS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tpss check failed");
`define TPSS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("tpss check failed");
`else
`define TPSS_ASSERT(name, prop)
`define TPSS_ASSERT_ALWAYS(name, prop)
`endif
`endif

// File: hdl/tpss_pkg.sv
`default_nettype none
package tpss_pkg;

  localparam int TOWERS   = 8192;
  localparam int ADC_BITS = 10;
  localparam int ENTRIES  = 2 * TOWERS;
  localparam int IDX_W    = $clog2(ENTRIES);

  localparam int CNT_W  = 32;
  localparam int FIX_W  = 11;
  localparam int BIT_W  = 4;
  localparam int TGT_W  = 40;
  localparam int ROOT_W = 40;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int PROD_W = 2 * CNT_W;

  // register byte addresses, index = paddr[2]
  localparam logic REG_MIN_SUM    = 1'b0;
  localparam logic REG_MIN_SPREAD = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] sq;
    logic [CNT_W-1:0] sum;
  } tpss_entry_t;

  localparam int ENTRY_W = $bits(tpss_entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_ACC,
    ST_MEAN,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIFF,
    ST_SQRT,
    ST_SIGMA,
    ST_DONE
  } tpss_state_t;

endpackage
`default_nettype wire

// File: hdl/tower_peak_slice_statistics_unit.sv
// Accumulate items: each passes through the lookup, update and output states;
// one item is in flight at a time, and output stalls hold off the next item.
// Read items: the steps are lookup, mean, products, root, sigma and output, in that
// order; the root and quotient units are bit-serial, and counts of 0 or 1 finish early.
// Output stalls add their own cycles.
// Reset is synchronous: thresholds return to 225 and 156, and a clearing pass writes
// all 16384 store entries to zero while no item is accepted.
`default_nettype none
`include "tower_peak_slice_statistics_unit_macros.svh"
module tower_peak_slice_statistics_unit
  import tpss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // layer[0], tower[13:1], sample_zero..sample_four[63:14] 10 bits each
  input  wire logic [63:0] s_tdata,
  // op[0]
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // qualified[0], peak_slice[3:1], hit_count[35:4], mean_fixed[46:36],
  // sigma_fixed[57:47], zero[63:58]
  output logic      [63:0] m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam logic [9:0] SMP_MASK = 10'((64'(1) << ADC_BITS) - 1);

  tpss_state_t state, state_next;

  logic [12:0] min_sum_of_five;
  logic [24:0] min_spread;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_sum_of_five <= 13'd225;
      min_spread      <= 25'd156;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_MIN_SUM:    min_sum_of_five <= pwdata[12:0];
        REG_MIN_SPREAD: min_spread      <= pwdata[24:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[2])
      REG_MIN_SUM:    prdata = 32'(min_sum_of_five);
      REG_MIN_SPREAD: prdata = 32'(min_spread);
      default:        prdata = '0;
    endcase
  end

  // input decode
  logic        in_layer;
  logic [12:0] in_tower;
  logic [IDX_W-1:0] in_idx;
  assign in_layer = s_tdata[0];
  assign in_tower = s_tdata[13:1];
  assign in_idx = in_layer ? IDX_W'(TOWERS) + IDX_W'(in_tower) : IDX_W'(in_tower);

  logic accept;
  assign accept = s_tvalid && s_tready;

  // item registers
  logic             op_r;
  logic             in_range_r;
  logic [IDX_W-1:0] idx_r;
  logic [9:0]       smp_r [5];

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= s_tuser[0];
      in_range_r <= 32'(in_tower) < 32'(TOWERS);
      idx_r      <= in_idx;
      for (int k = 0; k < 5; k++) begin
        smp_r[k] <= s_tdata[14 + 10*k +: 10] & SMP_MASK;
      end
    end
  end

  // store
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  tpss_entry_t      ram_wdata;
  tpss_entry_t      ram_rdata;
  logic [IDX_W-1:0] clr_addr;

  tpss_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES),
    .AW   (IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(in_idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // accumulate stage one: sums and peak
  logic [12:0] s_comb;
  logic [22:0] q_comb;
  logic [9:0]  best;
  logic [2:0]  peak_comb;
  always_comb begin
    s_comb    = '0;
    q_comb    = '0;
    best      = '0;
    peak_comb = '0;
    for (int k = 0; k < 5; k++) begin
      s_comb = s_comb + 13'(smp_r[k]);
      q_comb = q_comb + 23'(20'(smp_r[k]) * 20'(smp_r[k]));
      if (smp_r[k] > best) begin
        best      = smp_r[k];
        peak_comb = 3'(k);
      end
    end
  end

  logic [12:0] s_r;
  logic [22:0] q_r;
  logic [2:0]  peak_r;
  logic        found_r;
  tpss_entry_t ent_r;

  // accumulate stage two: spread and qualification
  logic [25:0] spread;
  logic        qual;
  assign spread = 26'(26'(q_r) * 26'd5) - 26'(26'(s_r) * 26'(s_r));
  assign qual = found_r && (s_r > min_sum_of_five) && (spread > 26'(min_spread));

  // shared 32x32 multiplier for the variance terms
  logic [CNT_W-1:0]  mul_x, mul_y;
  logic [PROD_W-1:0] prod_r, a_r;
  logic [PROD_W-1:0] d_val;

  // variance term, clamped at zero; stable while the root starts
  assign d_val = (a_r > prod_r) ? a_r - prod_r : '0;

  // units
  logic             div_start, div_done;
  logic [TGT_W-1:0] div_target;
  logic [FIX_W-1:0] div_quo;
  logic             sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  tpss_qdiv u_qdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (ent_r.cnt),
    .target(div_target),
    .done  (div_done),
    .quo   (div_quo)
  );

  tpss_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .value(d_val),
    .done (sqrt_done),
    .root (sqrt_root)
  );

  // result registers
  logic              res_qual;
  logic [2:0]        res_peak;
  logic [CNT_W-1:0]  res_hit;
  logic [FIX_W-1:0]  res_mean;
  logic [FIX_W-1:0]  res_sigma;

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == IDX_W'(ENTRIES - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_LOOK;
      ST_LOOK: begin
        if (!in_range_r) begin
          state_next = ST_DONE;
        end else if (!op_r) begin
          state_next = ST_ACC;
        end else if (ram_rdata.cnt == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MEAN;
        end
      end
      ST_ACC:   state_next = ST_DONE;
      ST_MEAN: begin
        if (div_done) begin
          state_next = (ent_r.cnt < CNT_W'(2)) ? ST_DONE : ST_MUL_A;
        end
      end
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_SQRT;
      ST_SQRT:  if (sqrt_done) state_next = ST_SIGMA;
      ST_SIGMA: if (div_done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = ent_r;
    mul_x      = ent_r.cnt;
    mul_y      = ent_r.sq;
    div_start  = 1'b0;
    div_target = TGT_W'({ent_r.sum, 8'h00});
    sqrt_start = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE:  s_tready = 1'b1;
      ST_LOOK:  div_start = in_range_r && op_r && (ram_rdata.cnt != '0);
      ST_ACC: begin
        ram_we = qual;
        ram_wdata.cnt = ent_r.cnt + 1'b1;
        ram_wdata.sum = ent_r.sum + CNT_W'(peak_r);
        ram_wdata.sq  = ent_r.sq + CNT_W'(5'(peak_r) * 5'(peak_r));
      end
      ST_MUL_B: begin
        mul_x = ent_r.sum;
        mul_y = ent_r.sum;
      end
      ST_DIFF:  sqrt_start = 1'b1;
      ST_SQRT: begin
        div_start  = sqrt_done;
        div_target = TGT_W'(sqrt_root);
      end
      ST_SIGMA: div_target = TGT_W'(sqrt_root);
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_x) * PROD_W'(mul_y);
    if (state == ST_LOOK) begin
      s_r     <= s_comb;
      q_r     <= q_comb;
      peak_r  <= peak_comb;
      found_r <= best != '0;
      ent_r   <= ram_rdata;
      res_qual  <= 1'b0;
      res_peak  <= '0;
      res_hit   <= in_range_r ? ram_rdata.cnt : '0;
      res_mean  <= '0;
      res_sigma <= '0;
    end
    if (state == ST_ACC && qual) begin
      res_qual <= 1'b1;
      res_peak <= peak_r;
      res_hit  <= ent_r.cnt + 1'b1;
    end
    if (state == ST_MEAN && div_done) res_mean <= div_quo;
    if (state == ST_MUL_B) a_r <= prod_r;
    if (state == ST_SIGMA && div_done) res_sigma <= div_quo;
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= 64'({res_sigma, res_mean, res_hit, res_peak, res_qual});
    end
  end

  `TPSS_ASSERT(a_no_accept_in_clear, (state == ST_CLEAR) |-> !s_tready)
  `TPSS_ASSERT(a_peak_range, (m_tvalid && m_tdata[0]) |-> (m_tdata[3:1] <= 3'd4))
  `TPSS_ASSERT(a_peak_unqualified, (m_tvalid && !m_tdata[0]) |-> (m_tdata[3:1] == 3'd0))
  `TPSS_ASSERT_ALWAYS(a_write_states, ram_we |-> (state == ST_CLEAR || state == ST_ACC))

endmodule
`default_nettype wire

// File: hdl/tpss_ram.sv
`default_nettype none
module tpss_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/tpss_sqrt.sv
`default_nettype none
// Integer square root, two radicand bits per cycle.
module tpss_sqrt
  import tpss_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [PROD_W-1:0]   value,   // root of value * 65536
  output logic                     done,
  output logic      [ROOT_W-1:0]   root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_BITS = $clog2(ROOT_W);

  logic [RAD_W-1:0]    rad;
  logic [REM_W-1:0]    rem;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                take;

  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root, 2'b01});
  assign take   = rem_sh >= trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(ROOT_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one root digit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'({value, 16'h0000});
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (take) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= REM_W'(rem_sh);
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/tpss_qdiv.sv
`default_nettype none
// Saturating quotient: largest q <= 2047 with q * den <= target.
// One quotient bit per cycle.
module tpss_qdiv
  import tpss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [CNT_W-1:0]  den,
  input  wire logic [TGT_W-1:0]  target,
  output logic                   done,
  output logic      [FIX_W-1:0]  quo
);

  localparam int MP_W = FIX_W + CNT_W;

  logic [BIT_W-1:0] bitn;
  logic             busy;
  logic [FIX_W-1:0] cand;
  logic [MP_W-1:0]  prod;

  assign cand = quo | (FIX_W'(1) << bitn);
  assign prod = MP_W'(cand) * MP_W'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bitn <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bitn <= BIT_W'(FIX_W - 1);
      end else if (busy) begin
        bitn <= bitn - 1'b1;
        if (bitn == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // trial bit kept when the product stays within target
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= '0;
    end else if (busy && (prod <= MP_W'(target))) begin
      quo <= cand;
    end
  end

endmodule
`default_nettype wire

// File: verif/tower_peak_slice_statistics_unit_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tower_peak_slice_statistics_unit_tb;
  import tpss_pkg::*;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;
  localparam logic [2:0] ADDR_MIN_SUM    = 3'd0;
  localparam logic [2:0] ADDR_MIN_SPREAD = 3'd4;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic        qualified;
    logic [2:0]  peak_slice;
    logic [31:0] hit_count;
    logic [10:0] mean_fixed;
    logic [10:0] sigma_fixed;
  } tower_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tower_peak_slice_statistics_unit dut (.*);

  // model state: thresholds and per-tower stores
  logic [12:0] min_sum_q;
  logic [24:0] min_spread_q;
  bit [31:0] sum_store [ENTRIES];
  bit [31:0] square_store [ENTRIES];
  bit [31:0] count_store [ENTRIES];

  tower_result_t pending_results [$];
  int errors = 0;
  int burst_left = 0;
  int gap_max = 4;
  int stall_pct = 30;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // floor(256*sqrt(d)/n), bit-serial search, n >= 2
  function automatic logic [10:0] tower_sigma(logic [63:0] d, logic [63:0] n);
    logic [127:0] target;
    logic [127:0] prod;
    logic [10:0] q;
    logic [10:0] c;
    int b;
    target = {48'b0, d, 16'b0};
    q = '0;
    for (b = 10; b >= 0; b--) begin
      c = q | (11'd1 << b);
      prod = 128'(c) * 128'(n);
      prod = prod * prod;
      if (prod <= target) q = c;
    end
    return q;
  endfunction

  // expected result of one item; updates the tower stores
  function automatic tower_result_t tower_update(logic op, logic layer, logic [12:0] tower,
                                                 logic [4:0][9:0] smp);
    tower_result_t r;
    int idx;
    int k;
    logic [63:0] s, q, spread, n, sm, sq, a, b, m;
    logic [9:0] best;
    logic [2:0] peak;
    r = '0;
    idx = int'(layer) * TOWERS + int'(tower);
    if (op == OP_ACCUM) begin
      s = 0; q = 0; best = 0; peak = 0;
      for (k = 0; k < 5; k++) begin
        s += smp[k];
        q += 64'(smp[k]) * smp[k];
        if (smp[k] > best) begin
          best = smp[k];
          peak = 3'(k);
        end
      end
      spread = 5 * q - s * s;
      if (best != 0 && s > min_sum_q && spread > min_spread_q) begin
        sum_store[idx] += peak;
        square_store[idx] += peak * peak;
        count_store[idx] += 1;
        r.qualified = 1'b1;
        r.peak_slice = peak;
      end
      r.hit_count = count_store[idx];
    end else begin
      n = count_store[idx];
      sm = sum_store[idx];
      sq = square_store[idx];
      r.hit_count = n[31:0];
      if (n != 0) begin
        m = (sm << 8) / n;
        r.mean_fixed = m > 2047 ? 11'd2047 : m[10:0];
        if (n >= 2) begin
          a = n * sq;
          b = sm * sm;
          r.sigma_fixed = tower_sigma(a > b ? a - b : 64'd0, n);
        end
      end
    end
    return r;
  endfunction

  // result side: compare and drive a stall pattern
  always @(posedge clk) begin
    tower_result_t got;
    tower_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[3:1], m_tdata[35:4], m_tdata[46:36], m_tdata[57:47]};
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.qualified !== want.qualified) begin
          $error("qualified exp %0d got %0d", want.qualified, got.qualified); errors++;
        end
        if (got.peak_slice !== want.peak_slice) begin
          $error("peak_slice exp %0d got %0d", want.peak_slice, got.peak_slice); errors++;
        end
        if (got.hit_count !== want.hit_count) begin
          $error("hit_count exp %0d got %0d", want.hit_count, got.hit_count); errors++;
        end
        if (got.mean_fixed !== want.mean_fixed) begin
          $error("mean_fixed exp %0d got %0d", want.mean_fixed, got.mean_fixed); errors++;
        end
        if (got.sigma_fixed !== want.sigma_fixed) begin
          $error("sigma_fixed exp %0d got %0d", want.sigma_fixed, got.sigma_fixed); errors++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // send one item, in bursts with random gaps
  task automatic send_item(logic op, logic layer, logic [12:0] tower, logic [4:0][9:0] smp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {14'b0, smp, tower, layer};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(tower_update(op, layer, tower, smp));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_MIN_SUM) min_sum_q = value[12:0];
    else min_spread_q = value[24:0];
  endtask

  task automatic set_thresholds(logic [12:0] min_sum, logic [24:0] min_spread);
    drain();
    write_reg(ADDR_MIN_SUM, 32'(min_sum));
    write_reg(ADDR_MIN_SPREAD, 32'(min_spread));
  endtask

  function automatic logic [4:0][9:0] pulse(int slice, logic [9:0] base, logic [9:0] top);
    logic [4:0][9:0] smp;
    int k;
    for (k = 0; k < 5; k++) smp[k] = base;
    smp[slice] = top;
    return smp;
  endfunction

  // extremes, every op, ties, empty and single-count reads
  task automatic test_directed();
    int k;
    send_item(OP_READ, 1'b0, 13'd0, '0);
    send_item(OP_ACCUM, 1'b0, 13'd0, '0);
    send_item(OP_ACCUM, 1'b0, 13'd0, {5{10'd1023}});
    send_item(OP_ACCUM, 1'b1, 13'd8191, pulse(4, 10'd0, 10'd1023));
    send_item(OP_READ, 1'b1, 13'd8191, '0);
    for (k = 0; k < 5; k++) send_item(OP_ACCUM, 1'b0, 13'd5, pulse(k, 10'd10, 10'd900));
    send_item(OP_ACCUM, 1'b0, 13'd5, {10'd0, 10'd800, 10'd3, 10'd800, 10'd0});
    send_item(OP_ACCUM, 1'b0, 13'd5, pulse(2, 10'd0, 10'd226));
    send_item(OP_ACCUM, 1'b0, 13'd5, pulse(2, 10'd0, 10'd225));
    send_item(OP_READ, 1'b0, 13'd5, {5{10'd1023}});
    send_item(OP_READ, 1'b1, 13'd5, '0);
    send_item(OP_ACCUM, 1'b1, 13'd4096, {10'd1023, 10'd0, 10'd1023, 10'd0, 10'd0});
    send_item(OP_READ, 1'b1, 13'd4096, '0);
  endtask

  // mostly peaked pulses on a few towers, some noise and reads
  task automatic test_random(int items);
    int i;
    int k;
    logic op;
    logic layer;
    logic [12:0] tower;
    logic [4:0][9:0] smp;
    for (i = 0; i < items; i++) begin
      op = ($urandom_range(99) < 30) ? OP_READ : OP_ACCUM;
      layer = $urandom_range(1);
      tower = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(7));
      if ($urandom_range(4) == 0) begin
        for (k = 0; k < 5; k++) smp[k] = 10'($urandom);
      end else begin
        for (k = 0; k < 5; k++) smp[k] = 10'($urandom_range(40));
        smp[$urandom_range(4)] = 10'($urandom_range(1023, 60));
        if ($urandom_range(7) == 0) smp[$urandom_range(4)] = smp[$urandom_range(4)];
      end
      send_item(op, layer, tower, smp);
    end
  endtask

  initial begin
    min_sum_q = 13'd225;
    min_spread_q = 25'd156;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(100);

    gap_max = 0; stall_pct = 0;
    set_thresholds(13'd0, 25'd0);
    test_random(110);

    gap_max = 6; stall_pct = 60;
    set_thresholds(13'd5115, 25'd26163225);
    test_random(40);

    gap_max = 3; stall_pct = 20;
    set_thresholds(13'($urandom_range(600)), 25'($urandom_range(200000)));
    test_random(110);

    set_thresholds(13'd225, 25'd156);
    test_random(80);

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
